// ===== rtl/fdl_pkg.sv =====
//------------------------------------------------------------------------------
// fdl_pkg: shared types and constants of the filtered derivative lowpass
// Field widths, datapath widths, step limits, register indexes, the
// sequencer and divider state types and the divider control structs.
//------------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

  // Stream field widths
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IN_TDATA_W = 96;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  // Step time limits in milliseconds
  localparam int unsigned MAX_STEP_MS      = 500;
  localparam int unsigned FALLBACK_STEP_MS = 1;

  // Datapath widths
  localparam int unsigned T_W     = 16;          // step time
  localparam int unsigned COEF_W  = 18;          // 2D - T, signed
  localparam int unsigned DEN_W   = 18;          // 2D + T, F + T
  localparam int unsigned LDEN_W  = 17;          // F + T
  localparam int unsigned DIFF_W  = DATA_W + 1;  // position difference
  localparam int unsigned MUL_A_W = 18;
  localparam int unsigned MUL_B_W = 34;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = 68;          // numerator accumulator
  localparam int unsigned DRV_W   = 51;          // unsaturated derivative
  localparam int unsigned SPLIT_W = 26;          // low half of derivative
  localparam int unsigned QUO_W   = 52;          // divider quotient bits

  // Divider step counts
  localparam int unsigned DIV_LONG_STEPS  = QUO_W;
  localparam int unsigned DIV_SHORT_STEPS = 32;
  localparam int unsigned DIV_CNT_W       = $clog2(DIV_LONG_STEPS);

  // Constants
  localparam logic signed [MUL_A_W-1:0] DERIV_GAIN = MUL_A_W'(2000);
  localparam logic [CFG_W-1:0] SMOOTH_RST = CFG_W'(10);
  localparam logic [CFG_W-1:0] DERIV_RST  = CFG_W'(10);
  localparam logic [DATA_W-1:0] VEL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VEL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_TIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_TIME  = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_COEF, S_MUL_A, S_MUL_B, S_MUL_C, S_DIV1, S_WAIT1,
    S_MUL_D, S_MUL_E, S_MUL_F, S_MUL_G, S_DIV2, S_WAIT2, S_OUT
  } seq_state_t;

  // Divider states
  typedef enum logic [2:0] {
    DV_IDLE, DV_ABS, DV_SPLIT, DV_RUN, DV_FIX
  } div_state_t;

  // Divider request and status
  typedef struct packed {
    logic start;
    logic short_q;   // 32 quotient bits with overflow check
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/fdl_mul.sv =====
//------------------------------------------------------------------------------
// fdl_mul: shared signed multiplier
// One 18 x 34 signed product per cycle, registered at the output.
//------------------------------------------------------------------------------
`default_nettype none

module fdl_mul (
  input  logic                                 clk,
  input  logic signed [fdl_pkg::MUL_A_W-1:0]   a,
  input  logic signed [fdl_pkg::MUL_B_W-1:0]   b,
  output logic signed [fdl_pkg::MUL_P_W-1:0]   p
);

  logic signed [fdl_pkg::MUL_P_W-1:0] p_r;

  // Register the full-width product
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ===== rtl/fdl_div.sv =====
//------------------------------------------------------------------------------
// fdl_div: serial rounding divider
// Signed numerator over an unsigned divisor, rounded to nearest with ties
// away from zero, one restoring quotient bit per cycle. The short mode
// forms 32 quotient bits and flags a quotient that does not fit.
//------------------------------------------------------------------------------
`default_nettype none

module fdl_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fdl_pkg::div_ctl_t                   ctl,
  input  logic signed [fdl_pkg::ACC_W-1:0]    num,
  input  logic [fdl_pkg::DEN_W-1:0]           den,
  output logic signed [fdl_pkg::QUO_W:0]      quo,
  output fdl_pkg::div_sts_t                   sts
);

  localparam int unsigned M_W  = fdl_pkg::ACC_W + 1;
  localparam int unsigned HI_W = M_W - fdl_pkg::DIV_SHORT_STEPS;

  fdl_pkg::div_state_t state_r, state_nxt;

  logic [M_W-1:0]                 m_r;
  logic                           neg_r;
  logic                           short_r;
  logic [fdl_pkg::DEN_W-1:0]      den_r;
  logic [fdl_pkg::DEN_W-1:0]      rem_r;
  logic [fdl_pkg::QUO_W-1:0]      low_r;
  logic [fdl_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           ovf_r;
  logic                           done_r;
  logic signed [fdl_pkg::QUO_W:0] quo_r;

  logic [HI_W-1:0]                hi;
  logic [fdl_pkg::DEN_W:0]        trial;
  logic [fdl_pkg::DEN_W+1:0]      sub;
  logic                           qbit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdl_pkg::DV_IDLE:  if (ctl.start) state_nxt = fdl_pkg::DV_ABS;
      fdl_pkg::DV_ABS:   state_nxt = fdl_pkg::DV_SPLIT;
      fdl_pkg::DV_SPLIT: state_nxt = fdl_pkg::DV_RUN;
      fdl_pkg::DV_RUN:   if (cnt_r == '0) state_nxt = fdl_pkg::DV_FIX;
      fdl_pkg::DV_FIX:   state_nxt = fdl_pkg::DV_IDLE;
      default:           state_nxt = fdl_pkg::DV_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    sts.done = done_r;
    sts.ovf  = ovf_r;
    quo      = quo_r;
  end

  // Top bits of the rounded magnitude that seed the remainder
  always_comb begin
    if (short_r) begin
      hi = m_r[M_W-1:fdl_pkg::DIV_SHORT_STEPS];
    end else begin
      hi = HI_W'(m_r[M_W-1:fdl_pkg::QUO_W]);
    end
  end

  // One restoring step
  always_comb begin
    trial = {rem_r, low_r[fdl_pkg::QUO_W-1]};
    sub   = {1'b0, trial} - {2'b00, den_r};
    qbit  = ~sub[fdl_pkg::DEN_W+1];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fdl_pkg::DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == fdl_pkg::DV_FIX);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      fdl_pkg::DV_IDLE: begin
        if (ctl.start) begin
          m_r     <= M_W'(num);
          neg_r   <= num[fdl_pkg::ACC_W-1];
          short_r <= ctl.short_q;
          den_r   <= den;
        end
      end
      // Magnitude plus half the divisor: negate by invert and add one
      fdl_pkg::DV_ABS: begin
        m_r <= (neg_r ? ~m_r : m_r) + M_W'(den_r >> 1) + M_W'(neg_r);
      end
      fdl_pkg::DV_SPLIT: begin
        ovf_r <= (hi >= HI_W'(den_r));
        rem_r <= hi[fdl_pkg::DEN_W-1:0];
        if (short_r) begin
          low_r <= {m_r[fdl_pkg::DIV_SHORT_STEPS-1:0],
                    {(fdl_pkg::QUO_W-fdl_pkg::DIV_SHORT_STEPS){1'b0}}};
          cnt_r <= fdl_pkg::DIV_CNT_W'(fdl_pkg::DIV_SHORT_STEPS - 1);
        end else begin
          low_r <= m_r[fdl_pkg::QUO_W-1:0];
          cnt_r <= fdl_pkg::DIV_CNT_W'(fdl_pkg::DIV_LONG_STEPS - 1);
        end
      end
      // Shift in one quotient bit, keep the remainder below the divisor
      fdl_pkg::DV_RUN: begin
        rem_r <= qbit ? sub[fdl_pkg::DEN_W-1:0] : trial[fdl_pkg::DEN_W-1:0];
        low_r <= {low_r[fdl_pkg::QUO_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
      end
      // Restore the sign
      fdl_pkg::DV_FIX: begin
        quo_r <= neg_r ? -$signed({1'b0, low_r}) : $signed({1'b0, low_r});
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/filtered_derivative_lowpass_top.sv =====
//------------------------------------------------------------------------------
// filtered_derivative_lowpass_top: filtered derivative with lowpass smoothing
// Tustin filtered derivative of a Q16.16 position followed by a first-order
// lowpass, saturated to 32 bits.
//------------------------------------------------------------------------------
// Each input beat carries a millisecond tick, a Q16.16 position and the
// previous Q16.16 velocity; the block answers with one saturated velocity
// beat. The step time is the wrapping tick difference, replaced by 1 ms when
// above 500 ms. One item is handled at a time: in_tready drops at the
// accepting edge and returns once the result beat is taken. A divide is
// skipped when its denominator, 2*deriv_time_ms + T or smooth_time_ms + T,
// is zero. The single serial divider produces one quotient bit per cycle:
// 52 bits for the derivative and 32 for the lowpass; all products go
// through one shared 18 x 34 multiplier. Configuration writes take effect
// at once and are meant for idle periods only.
//------------------------------------------------------------------------------
`default_nettype none

module filtered_derivative_lowpass_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata: tick_ms [31:0], position [63:32], last_velocity [95:64]
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fdl_pkg::IN_TDATA_W-1:0]     in_tdata,
  // out_tdata: velocity [31:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fdl_pkg::DATA_W-1:0]         out_tdata,
  input  logic                               cfg_we,
  input  logic [fdl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fdl_pkg::CFG_W-1:0]          cfg_wdata
);

  fdl_pkg::seq_state_t state_r, state_nxt;

  // Configuration
  logic [fdl_pkg::CFG_W-1:0] ftime_r;
  logic [fdl_pkg::CFG_W-1:0] dtime_r;

  // Stored state
  logic [fdl_pkg::TICK_W-1:0]        last_tick_r;
  logic signed [fdl_pkg::DATA_W-1:0] last_pos_r;
  logic signed [fdl_pkg::DATA_W-1:0] last_out_r;

  // Item and working registers
  logic [fdl_pkg::TICK_W-1:0]        tick_r;
  logic signed [fdl_pkg::DATA_W-1:0] pos_r;
  logic signed [fdl_pkg::DATA_W-1:0] vel_r;
  logic [fdl_pkg::T_W-1:0]           t_r;
  logic signed [fdl_pkg::COEF_W-1:0] c_r;
  logic [fdl_pkg::DEN_W-1:0]         den1_r;
  logic [fdl_pkg::LDEN_W-1:0]        lden_r;
  logic signed [fdl_pkg::DIFF_W-1:0] diff_r;
  logic signed [fdl_pkg::ACC_W-1:0]  acc_r;
  logic signed [fdl_pkg::DRV_W-1:0]  drv_r;
  logic [fdl_pkg::DATA_W-1:0]        res_r;

  logic [fdl_pkg::TICK_W-1:0]         dt;
  logic signed [fdl_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fdl_pkg::MUL_B_W-1:0] mul_b;
  logic signed [fdl_pkg::MUL_P_W-1:0] prod;
  logic signed [fdl_pkg::ACC_W-1:0]   prod_x;
  fdl_pkg::div_ctl_t                  div_ctl;
  fdl_pkg::div_sts_t                  div_sts;
  logic [fdl_pkg::DEN_W-1:0]          div_den;
  logic signed [fdl_pkg::QUO_W:0]     quo;
  logic                               commit;
  logic [fdl_pkg::DATA_W-1:0]         res_nxt;

  // Clamp a wide signed value to the 32-bit range
  function automatic logic [fdl_pkg::DATA_W-1:0] sat32(
    input logic signed [fdl_pkg::QUO_W:0] v
  );
    logic [fdl_pkg::QUO_W-fdl_pkg::DATA_W+1:0] top;
    top = v[fdl_pkg::QUO_W:fdl_pkg::DATA_W-1];
    if ((&top) || !(|top)) begin
      return v[fdl_pkg::DATA_W-1:0];
    end
    return v[fdl_pkg::QUO_W] ? fdl_pkg::VEL_MIN : fdl_pkg::VEL_MAX;
  endfunction

  fdl_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  fdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (acc_r),
    .den   (div_den),
    .quo   (quo),
    .sts   (div_sts)
  );

  assign prod_x = fdl_pkg::ACC_W'(prod);
  assign dt     = tick_r - last_tick_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fdl_pkg::S_IDLE:  if (in_tvalid) state_nxt = fdl_pkg::S_STEP;
      fdl_pkg::S_STEP:  state_nxt = fdl_pkg::S_COEF;
      fdl_pkg::S_COEF:  state_nxt = fdl_pkg::S_MUL_A;
      fdl_pkg::S_MUL_A: state_nxt = fdl_pkg::S_MUL_B;
      fdl_pkg::S_MUL_B: state_nxt = fdl_pkg::S_MUL_C;
      fdl_pkg::S_MUL_C: state_nxt = fdl_pkg::S_DIV1;
      fdl_pkg::S_DIV1: begin
        state_nxt = (den1_r == '0) ? fdl_pkg::S_MUL_D : fdl_pkg::S_WAIT1;
      end
      fdl_pkg::S_WAIT1: if (div_sts.done) state_nxt = fdl_pkg::S_MUL_D;
      fdl_pkg::S_MUL_D: state_nxt = fdl_pkg::S_MUL_E;
      fdl_pkg::S_MUL_E: state_nxt = fdl_pkg::S_MUL_F;
      fdl_pkg::S_MUL_F: state_nxt = fdl_pkg::S_MUL_G;
      fdl_pkg::S_MUL_G: state_nxt = fdl_pkg::S_DIV2;
      fdl_pkg::S_DIV2: begin
        state_nxt = (lden_r == '0) ? fdl_pkg::S_OUT : fdl_pkg::S_WAIT2;
      end
      fdl_pkg::S_WAIT2: if (div_sts.done) state_nxt = fdl_pkg::S_OUT;
      fdl_pkg::S_OUT:   if (out_tready) state_nxt = fdl_pkg::S_IDLE;
      default:          state_nxt = fdl_pkg::S_IDLE;
    endcase
  end

  // Handshakes, multiplier operands and divider requests
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_ctl    = '0;
    div_den    = den1_r;
    case (state_r)
      fdl_pkg::S_IDLE: in_tready = 1'b1;
      // (2D - T) * last_velocity
      fdl_pkg::S_MUL_A: begin
        mul_a = c_r;
        mul_b = fdl_pkg::MUL_B_W'(vel_r);
      end
      // 2000 * position difference
      fdl_pkg::S_MUL_B: begin
        mul_a = fdl_pkg::DERIV_GAIN;
        mul_b = fdl_pkg::MUL_B_W'(diff_r);
      end
      fdl_pkg::S_DIV1: div_ctl.start = (den1_r != '0);
      // F * last output
      fdl_pkg::S_MUL_D: begin
        mul_a = $signed({2'b00, ftime_r});
        mul_b = fdl_pkg::MUL_B_W'(last_out_r);
      end
      // T * derivative, low half then high half
      fdl_pkg::S_MUL_E: begin
        mul_a = $signed({2'b00, t_r});
        mul_b = $signed({{(fdl_pkg::MUL_B_W-fdl_pkg::SPLIT_W){1'b0}},
                         drv_r[fdl_pkg::SPLIT_W-1:0]});
      end
      fdl_pkg::S_MUL_F: begin
        mul_a = $signed({2'b00, t_r});
        mul_b = fdl_pkg::MUL_B_W'($signed(drv_r[fdl_pkg::DRV_W-1:fdl_pkg::SPLIT_W]));
      end
      fdl_pkg::S_DIV2: begin
        div_ctl.start   = (lden_r != '0);
        div_ctl.short_q = 1'b1;
        div_den         = fdl_pkg::DEN_W'(lden_r);
      end
      fdl_pkg::S_OUT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  // Final result and the moment it is known
  always_comb begin
    commit  = 1'b0;
    res_nxt = sat32(quo);
    if (state_r == fdl_pkg::S_DIV2) begin
      commit  = (lden_r == '0);
      res_nxt = sat32((fdl_pkg::QUO_W+1)'(drv_r));
    end else if (state_r == fdl_pkg::S_WAIT2) begin
      commit = div_sts.done;
      if (div_sts.ovf) begin
        res_nxt = acc_r[fdl_pkg::ACC_W-1] ? fdl_pkg::VEL_MIN : fdl_pkg::VEL_MAX;
      end
    end
  end

  // Control state, configuration and stored samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fdl_pkg::S_IDLE;
      ftime_r     <= fdl_pkg::SMOOTH_RST;
      dtime_r     <= fdl_pkg::DERIV_RST;
      last_tick_r <= '0;
      last_pos_r  <= '0;
      last_out_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fdl_pkg::CFG_SMOOTH_TIME: ftime_r <= cfg_wdata;
          fdl_pkg::CFG_DERIV_TIME:  dtime_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (commit) begin
        last_tick_r <= tick_r;
        last_pos_r  <= pos_r;
        last_out_r  <= $signed(res_nxt);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (commit) begin
      res_r <= res_nxt;
    end
    case (state_r)
      fdl_pkg::S_IDLE: begin
        if (in_tvalid) begin
          tick_r <= in_tdata[fdl_pkg::TICK_W-1:0];
          pos_r  <= $signed(in_tdata[2*fdl_pkg::DATA_W-1:fdl_pkg::DATA_W]);
          vel_r  <= $signed(in_tdata[3*fdl_pkg::DATA_W-1:2*fdl_pkg::DATA_W]);
        end
      end
      // Step time with the long-step fallback
      fdl_pkg::S_STEP: begin
        if (dt > fdl_pkg::TICK_W'(fdl_pkg::MAX_STEP_MS)) begin
          t_r <= fdl_pkg::T_W'(fdl_pkg::FALLBACK_STEP_MS);
        end else begin
          t_r <= dt[fdl_pkg::T_W-1:0];
        end
      end
      // Coefficients, denominators and position difference
      fdl_pkg::S_COEF: begin
        c_r    <= $signed({1'b0, dtime_r, 1'b0}) - $signed({2'b00, t_r});
        den1_r <= {1'b0, dtime_r, 1'b0} + {2'b00, t_r};
        lden_r <= {1'b0, ftime_r} + {1'b0, t_r};
        diff_r <= fdl_pkg::DIFF_W'(pos_r) - fdl_pkg::DIFF_W'(last_pos_r);
      end
      fdl_pkg::S_MUL_B: acc_r <= prod_x;
      fdl_pkg::S_MUL_C: acc_r <= acc_r + prod_x;
      // Zero denominator gives a zero derivative
      fdl_pkg::S_DIV1: if (den1_r == '0) drv_r <= '0;
      fdl_pkg::S_WAIT1: if (div_sts.done) drv_r <= quo[fdl_pkg::DRV_W-1:0];
      fdl_pkg::S_MUL_E: acc_r <= prod_x;
      fdl_pkg::S_MUL_F: acc_r <= acc_r + prod_x;
      fdl_pkg::S_MUL_G: acc_r <= acc_r + (prod_x <<< fdl_pkg::SPLIT_W);
      default: ;
    endcase
  end

  assign out_tdata = res_r;

endmodule

`default_nettype wire

// ===== rtl/fdl_chk.sv =====
//------------------------------------------------------------------------------
// fdl_chk: port checker of the filtered derivative lowpass
// Watches the stream handshakes of the top level over time.
//------------------------------------------------------------------------------
`default_nettype none

module fdl_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [fdl_pkg::DATA_W-1:0]  out_tdata
);

  // Never take a new beat while a result is on offer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  // An accepted beat closes the input and cannot yield a result at once
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("block not busy after input beat");

  // A taken result reopens the input
  a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> (in_tready && !out_tvalid))
    else $error("input not reopened after result beat");

  // Hold a stalled result
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind filtered_derivative_lowpass_top fdl_chk u_fdl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
